/* rtl/distance_vector_route_table_assert.svh */
// assertion macros shared by the route table modules
// no dependencies
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define DVRT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dvrt assertion failed");
// implication with the consequent checked in the next cycle
`define DVRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dvrt assertion failed");
`endif

/* rtl/dvrt_pkg.sv */
// types, constants and helpers for the distance-vector route table
// no dependencies
package dvrt_pkg;
  localparam int RouteEntries = 16;
  localparam int NbrEntries   = 8;
  localparam int DownLimit    = 3;
  localparam int RIdxW = $clog2(RouteEntries);
  localparam int NIdxW = $clog2(NbrEntries);
  localparam logic [26:0] INF_COST = 27'd99999999;
  localparam logic [1:0]  MISS_MAX = 2'd3;

  localparam logic [2:0] ACT_ADVERT = 3'd0;
  localparam logic [2:0] ACT_COST   = 3'd1;
  localparam logic [2:0] ACT_TICK   = 3'd2;
  localparam logic [2:0] ACT_LOOKUP = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_ADD    = 3'd5;

  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_INVAL  = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_UNREACH = 3'd3;
  localparam logic [2:0] ST_SELF   = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    logic [26:0] cost_in;
    logic [3:0]  entry_index;
  } dvrt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        changed;
    logic [31:0] next_hop;
    logic [31:0] entry_dest;
    logic [26:0] entry_cost;
    logic        entry_valid;
  } dvrt_out_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;       // latch input word
    logic rscan_clr;  // restart route scan
    logic rscan_step; // compare one route entry
    logic nscan_clr;
    logic nscan_step;
    logic rkey_b;     // route search key: 1 addr_b, 0 nbr/other address
    logic nkey_b;     // nbr search key: 1 addr_b, 0 addr_a
    logic tick_inc;   // age all neighbours
    logic tick_chk;   // down check for neighbour at scan index
    logic rd_route;   // read route at hit index
    logic rd_nbr;
    logic execute;    // apply action and form result
  } dvrt_cmd_t;

  typedef struct packed {
    logic rscan_done;
    logic nscan_done;
    logic nscan_end;  // all neighbours visited in tick
  } dvrt_sts_t;

  function automatic logic [26:0] sat_add(input logic [26:0] x, input logic [26:0] y);
    logic [27:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s > {1'b0, INF_COST}) ? INF_COST : s[26:0];
  endfunction
endpackage

/* rtl/dvrt_ram.sv */
// generic single-port ram with registered read
// no dependencies
module dvrt_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/dvrt_ctrl.sv */
// sequencer for the route table: scans, reads, apply step
// depends on dvrt_pkg and distance_vector_route_table_assert.svh
module dvrt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         action,
  input  dvrt_pkg::dvrt_sts_t sts,
  output dvrt_pkg::dvrt_cmd_t cmd,
  output logic               busy
);
  import dvrt_pkg::*;
  `include "distance_vector_route_table_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_NSCAN, S_NSCAN2, S_RSCAN, S_RD, S_RDW, S_EXEC,
    S_TINC, S_TCHK_R, S_TCHK_RD, S_TCHK_RDW, S_TCHK, S_TNEXT
  } state_t;
  state_t state;
  logic [2:0] act;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act <= ACT_ADVERT;
    end else begin
      case (state)
        S_IDLE: if (start) begin
          act <= action;
          state <= (action == ACT_TICK) ? S_TINC : S_NSCAN;
        end
        S_NSCAN: if (sts.nscan_done) begin
          state <= (act == ACT_COST) ? S_NSCAN2 : S_RSCAN;
        end
        S_NSCAN2: if (sts.nscan_done) state <= S_RSCAN;
        S_RSCAN: if (sts.rscan_done) state <= S_RD;
        S_RD: state <= S_RDW;
        S_RDW: state <= S_EXEC;
        S_EXEC: state <= S_IDLE;
        // all neighbours age together in S_TINC
        S_TINC: state <= S_TCHK_R;
        S_TCHK_R: if (sts.nscan_end) state <= S_EXEC;
          else state <= S_TCHK_RD;
        S_TCHK_RD: if (sts.rscan_done) state <= S_TCHK_RDW;
        S_TCHK_RDW: state <= S_TCHK;
        S_TCHK: state <= S_TNEXT;
        S_TNEXT: state <= S_TCHK_R;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && start;
    cmd.nscan_clr = cmd.load;
    cmd.rscan_clr = cmd.load;
    case (state)
      S_NSCAN: begin
        cmd.nscan_step = 1'b1;
        cmd.nkey_b = (act == ACT_COST);
        if (sts.nscan_done && act == ACT_COST) cmd.nscan_clr = 1'b1;
      end
      S_NSCAN2: cmd.nscan_step = 1'b1;
      S_RSCAN: begin
        cmd.rscan_step = 1'b1;
        cmd.rkey_b = (act == ACT_ADVERT);
      end
      // hold the read addresses so the data is still there at execute
      S_RD, S_RDW: begin
        cmd.rd_route = 1'b1;
        cmd.rd_nbr = 1'b1;
      end
      S_EXEC: cmd.execute = 1'b1;
      S_TINC: begin
        cmd.tick_inc = 1'b1;
        cmd.nscan_clr = 1'b1;
      end
      S_TCHK_R: begin
        cmd.rd_nbr = 1'b1;
        cmd.rscan_clr = 1'b1;
      end
      S_TCHK_RD: cmd.rscan_step = 1'b1;
      S_TCHK_RDW: cmd.rd_route = 1'b1;
      S_TCHK: cmd.tick_chk = 1'b1;
      S_TNEXT: cmd.nscan_step = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  `DVRT_ASSERT_NEXT(a_start_busy, (state == S_IDLE) && start, busy)
  `DVRT_ASSERT_NEXT(a_exec_idle, cmd.execute, !busy)
  `DVRT_ASSERT_IMP(a_exec_once, cmd.execute, !cmd.load)
endmodule

/* rtl/dvrt_dp.sv */
// datapath: route and neighbour stores, scan counters, update logic
// depends on dvrt_pkg, dvrt_ram and distance_vector_route_table_assert.svh
module dvrt_dp (
  input  logic                clk,
  input  logic                rst,
  input  dvrt_pkg::dvrt_in_t  in_word,
  input  logic [31:0]         own_address,
  input  dvrt_pkg::dvrt_cmd_t cmd,
  output dvrt_pkg::dvrt_sts_t sts,
  output logic                done,
  output dvrt_pkg::dvrt_out_t result
);
  import dvrt_pkg::*;
  `include "distance_vector_route_table_assert.svh"

  dvrt_in_t         req;
  logic [RIdxW:0]   route_count;
  logic [NIdxW:0]   nbr_count;
  logic [26:0]      cost;
  // route memory: dest, hop, cost
  localparam int RW = 32 + 32 + 27;
  localparam int NW = 32 + 27;
  logic             r_we;
  logic [RIdxW-1:0] r_addr;
  logic [RW-1:0]    r_wdata, r_rdata;
  logic             n_we;
  logic [NIdxW-1:0] n_addr;
  logic [NW-1:0]    n_wdata, n_rdata;
  // up and miss count in flops (small, aged in place)
  logic [NbrEntries-1:0] nbr_up;
  logic [1:0]       nbr_missed [NbrEntries];

  // scan state
  logic [RIdxW:0]   rptr;
  logic             rhit, rhit_next;
  logic [RIdxW-1:0] ridx;
  logic [NIdxW:0]   nptr;
  logic             nhit, nhit_a;
  logic [NIdxW-1:0] nidx;
  logic             other_b;  // cost change: other end is addr_b
  logic             cc_ok;
  logic             rkey_b_q;
  logic             rd_pend;  // route compare pending on registered data

  logic [31:0] r_dest, r_hop;
  logic [26:0] r_cost, n_link;
  logic [31:0] n_addr_q;
  assign r_dest = r_rdata[RW-1 -: 32];
  assign r_hop  = r_rdata[58:27];
  assign r_cost = r_rdata[26:0];
  assign n_addr_q = n_rdata[NW-1 -: 32];
  assign n_link   = n_rdata[26:0];

  logic [31:0] rkey;
  logic [31:0] other;
  always_comb begin
    other = other_b ? req.addr_b : req.addr_a;
    if (req.action == ACT_TICK) rkey = n_addr_q;
    // an advert about this router itself updates the sender's direct route
    else if (rkey_b_q && req.addr_b != own_address) rkey = req.addr_b;
    else if (req.action == ACT_COST) rkey = other;
    else rkey = req.addr_a;
  end

  // route scan: issue read at rptr, compare in the next cycle on the registered data
  logic r_scan_end;
  assign r_scan_end = (rptr >= route_count);
  assign sts.rscan_done = !rd_pend && (rhit || r_scan_end);
  assign sts.nscan_done = !rd_pend && (nhit || (nptr >= nbr_count));
  assign sts.nscan_end  = (nptr >= nbr_count);

  // read-entry result
  logic rd_ok;
  assign rd_ok = ({1'b0, req.entry_index} < (5)'(route_count));

  logic tick_chg;

  // execute-time decisions
  logic [31:0] e_hop;
  logic [26:0] e_cost;
  logic        e_rwe, e_rnew, e_nwe, e_nnew, e_chg;
  logic [2:0]  e_st;
  logic [26:0] total;
  dvrt_out_t   e_out;
  assign total = sat_add(cost, n_link);

  always_comb begin
    e_hop = r_hop; e_cost = r_cost; e_rwe = 1'b0; e_rnew = 1'b0;
    e_nwe = 1'b0; e_nnew = 1'b0; e_chg = 1'b0; e_st = ST_DONE;
    e_out = '0;
    case (req.action)
      ACT_ADVERT: begin
        if (!nhit) e_st = ST_INVAL;
        else if (req.addr_b == own_address) begin
          if (rhit && r_cost >= n_link) begin
            e_hop = req.addr_a; e_cost = n_link; e_rwe = 1'b1;
            e_chg = (r_hop != req.addr_a) || (r_cost != n_link);
          end
        end else if (!rhit) begin
          if (route_count >= (RIdxW+1)'(RouteEntries)) e_st = ST_FULL;
          else begin
            e_hop = req.addr_a; e_cost = total; e_rwe = 1'b1; e_rnew = 1'b1;
            e_chg = 1'b1;
          end
        end else if (r_hop == req.addr_a && r_cost != total) begin
          e_cost = total; e_rwe = 1'b1; e_chg = 1'b1;
        end else if (r_cost > total) begin
          e_hop = req.addr_a; e_cost = total; e_rwe = 1'b1;
          e_chg = (r_hop != req.addr_a) || (r_cost != total);
        end
      end
      ACT_COST: begin
        if (!cc_ok) e_st = ST_INVAL;
        else begin
          e_nwe = 1'b1;
          if (rhit) begin
            if (r_hop == other) begin
              e_cost = cost; e_rwe = 1'b1; e_chg = (r_cost != cost);
            end else if (r_cost >= cost) begin
              e_hop = other; e_cost = cost; e_rwe = 1'b1;
              e_chg = (r_hop != other) || (r_cost != cost);
            end
          end
        end
      end
      ACT_TICK: e_chg = tick_chg;
      ACT_LOOKUP: begin
        if (req.addr_a == own_address) e_st = ST_SELF;
        else if (!rhit || r_cost >= INF_COST) e_st = ST_UNREACH;
        else e_out.next_hop = r_hop;
      end
      ACT_READ: begin
        if (rd_ok) begin
          e_out.entry_valid = 1'b1;
          e_out.entry_dest = r_dest;
          e_out.next_hop = r_hop;
          e_out.entry_cost = r_cost;
        end
      end
      ACT_ADD: begin
        if (req.addr_a == own_address) e_st = ST_SELF;
        else if ((!nhit && nbr_count >= (NIdxW+1)'(NbrEntries)) ||
                 (!rhit && route_count >= (RIdxW+1)'(RouteEntries))) e_st = ST_FULL;
        else begin
          if (!rhit) begin
            e_hop = req.addr_a; e_cost = cost; e_rwe = 1'b1; e_rnew = 1'b1;
            e_chg = 1'b1;
          end else if (r_cost > cost) begin
            e_hop = req.addr_a; e_cost = cost; e_rwe = 1'b1;
            e_chg = (r_hop != req.addr_a) || (r_cost != cost);
          end
          e_nnew = !nhit;
          e_nwe = !nhit;
        end
      end
      default: e_st = ST_INVAL;
    endcase
    e_out.status = e_st;
    e_out.changed = e_chg;
  end

  // tick down check
  logic t_down;
  assign t_down = (nbr_missed[nidx] >= 2'(DownLimit));
  logic t_rw;
  assign t_rw = t_down && rhit && (r_hop == n_addr_q);

  // memory ports
  always_comb begin
    r_we = 1'b0; n_we = 1'b0;
    r_addr = rptr[RIdxW-1:0];
    n_addr = nptr[NIdxW-1:0];
    r_wdata = {r_dest, r_hop, r_cost};
    n_wdata = {n_addr_q, n_link};
    if (cmd.rd_route) r_addr = (req.action == ACT_READ) ? req.entry_index[RIdxW-1:0] : ridx;
    if (cmd.rd_nbr && req.action != ACT_TICK) n_addr = nidx;
    if (cmd.execute) begin
      r_addr = e_rnew ? route_count[RIdxW-1:0] : ridx;
      r_we = e_rwe;
      r_wdata = e_rnew ? {(req.action == ACT_ADVERT) ? req.addr_b : req.addr_a, e_hop, e_cost}
                       : {r_dest, e_hop, e_cost};
      n_addr = e_nnew ? nbr_count[NIdxW-1:0] : nidx;
      n_we = e_nwe;
      n_wdata = e_nnew ? {req.addr_a, cost} : {n_addr_q, cost};
    end
    if (cmd.tick_chk) begin
      r_addr = ridx;
      r_we = t_rw;
      r_wdata = {r_dest, r_hop, INF_COST};
    end
  end

  dvrt_ram #(.Width(RW), .Depth(RouteEntries)) u_rram (
    .clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wdata), .rdata(r_rdata));
  dvrt_ram #(.Width(NW), .Depth(NbrEntries)) u_nram (
    .clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wdata), .rdata(n_rdata));

  assign rhit_next = rd_pend && !rhit && (r_dest == rkey);

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
      nbr_count <= '0;
      rptr <= '0; nptr <= '0;
      rhit <= 1'b0; nhit <= 1'b0; rd_pend <= 1'b0;
      done <= 1'b0; tick_chg <= 1'b0;
      nbr_up <= '0;
      for (int i = 0; i < NbrEntries; i++) nbr_missed[i] <= '0;
    end else begin
      done <= cmd.execute;
      if (cmd.load) begin
        req <= in_word;
        cost <= (in_word.cost_in > INF_COST) ? INF_COST : in_word.cost_in;
        other_b <= 1'b0; cc_ok <= 1'b0; tick_chg <= 1'b0;
      end
      // route scan
      if (cmd.rscan_clr) begin
        rptr <= '0; rhit <= 1'b0; rd_pend <= 1'b0;
      end else if (cmd.rscan_step) begin
        rkey_b_q <= cmd.rkey_b;
        if (rhit_next) begin
          rhit <= 1'b1; ridx <= rptr[RIdxW-1:0] - 1'b1; rd_pend <= 1'b0;
        end else if (!rhit && !r_scan_end) begin
          rptr <= rptr + 1'b1; rd_pend <= 1'b1;
        end else rd_pend <= 1'b0;
      end
      // neighbour scan (also walks the tick)
      if (cmd.nscan_clr) begin
        nptr <= '0; nhit <= 1'b0;
        if (cmd.nscan_step && !cmd.load) begin
          // first search of a cost change finished: choose the other end
          if (req.addr_a == own_address && req.addr_b != own_address &&
              (nhit || nhit_a)) begin
            other_b <= 1'b1; cc_ok <= 1'b1;
          end
        end
      end else if (cmd.nscan_step && req.action != ACT_TICK) begin
        if (!nhit && nptr < nbr_count) nptr <= nptr + 1'b1;
        if (nhit_a && !nhit) begin
          nhit <= 1'b1; nidx <= nptr[NIdxW-1:0] - 1'b1;
          if (req.action == ACT_COST && !cmd.nkey_b && !cc_ok && !other_b &&
              req.addr_b == own_address && req.addr_a != own_address) cc_ok <= 1'b1;
        end
      end else if (cmd.nscan_step) begin
        nptr <= nptr + 1'b1; nidx <= nptr[NIdxW-1:0] + 1'b1;
      end
      if (cmd.tick_inc) begin
        for (int i = 0; i < NbrEntries; i++)
          if ((NIdxW+1)'(i) < nbr_count && nbr_missed[i] < MISS_MAX)
            nbr_missed[i] <= nbr_missed[i] + 2'd1;
      end
      if (cmd.nscan_clr && req.action == ACT_TICK) nidx <= '0;
      if (cmd.tick_chk) begin
        if (t_down) nbr_up[nidx] <= 1'b0;
        if (t_rw && r_cost != INF_COST) tick_chg <= 1'b1;
      end
      if (cmd.execute) begin
        if (e_rnew) route_count <= route_count + 1'b1;
        if (e_nnew) begin
          nbr_count <= nbr_count + 1'b1;
          nbr_up[nbr_count[NIdxW-1:0]] <= 1'b1;
          nbr_missed[nbr_count[NIdxW-1:0]] <= '0;
        end
        if (req.action == ACT_ADVERT && nhit) begin
          nbr_up[nidx] <= 1'b1; nbr_missed[nidx] <= '0;
        end
        result <= e_out;
      end
    end
  end

  // neighbour compare uses registered read of the previous address
  logic nrd_pend;
  always_ff @(posedge clk) begin
    if (rst) nrd_pend <= 1'b0;
    else nrd_pend <= cmd.nscan_step && !cmd.nscan_clr && (nptr < nbr_count) && !nhit;
  end
  // cost change: first pass looks for addr_b, second for the chosen other end
  assign nhit_a = nrd_pend &&
    (n_addr_q == ((req.action == ACT_COST && (cmd.nkey_b || other_b)) ? req.addr_b :
                  req.addr_a));

  `DVRT_ASSERT_IMP(a_rcount, 1'b1, route_count <= (RIdxW+1)'(RouteEntries))
  `DVRT_ASSERT_IMP(a_ncount, 1'b1, nbr_count <= (NIdxW+1)'(NbrEntries))
  `DVRT_ASSERT_NEXT(a_done, cmd.execute, done)
endmodule

/* rtl/distance_vector_route_table.sv */
// distance-vector route table: top level, apb register, result strobe
// depends on dvrt_pkg, dvrt_ctrl, dvrt_dp
//
// usage: hold start with a command word on cmd_word while busy is low; the
// word is taken at that edge and busy rises. the block scans its neighbour
// table (up to 8 entries, twice for a cost change) and route table (up to 16
// entries) one entry per cycle through single-port memories, then applies
// the update. a tick ages all neighbours together, then walks every
// neighbour and searches its direct route.
// one command at a time: busy is low again in the done cycle, so the next
// word can be taken at the edge that ends it.
// each result word shows on result for one cycle with done high; the
// receiver cannot stall and must take it then.
// own_address sits at apb address 0; write it only while busy is low.
// reset (rst, synchronous) empties both tables and clears own_address.
module distance_vector_route_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dvrt_pkg::dvrt_in_t cmd_word,
  output logic               busy,
  output logic               done,
  output dvrt_pkg::dvrt_out_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dvrt_pkg::*;

  logic [31:0] own_address;
  dvrt_cmd_t   cmd;
  dvrt_sts_t   sts;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) own_address <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) own_address <= pwdata;
  end
  assign prdata = (paddr == 2'd0) ? own_address : 32'd0;

  dvrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(cmd_word.action),
    .sts(sts), .cmd(cmd), .busy(busy));

  dvrt_dp u_dp (
    .clk(clk), .rst(rst), .in_word(cmd_word), .own_address(own_address),
    .cmd(cmd), .sts(sts), .done(done), .result(result));
endmodule

/* test/testbench.sv */
// testbench for the distance-vector route table: directed and random commands
// checked against a behavioral table model kept in the testbench
// depends on dvrt_pkg and distance_vector_route_table
module testbench;
  import dvrt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  dvrt_in_t cmd_word = '0;
  logic busy, done;
  dvrt_out_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  distance_vector_route_table dut (
    .clk(clk), .rst(rst), .start(start), .cmd_word(cmd_word), .busy(busy),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // table model
  logic [31:0] my_addr;
  logic [31:0] rt_dest [RouteEntries];
  logic [31:0] rt_hop [RouteEntries];
  logic [26:0] rt_cost [RouteEntries];
  int rt_n;
  logic [31:0] nb_addr [NbrEntries];
  logic [26:0] nb_cost [NbrEntries];
  logic nb_up [NbrEntries];
  logic [1:0] nb_miss [NbrEntries];
  int nb_n;

  dvrt_out_t expected_words[$];
  bit failed = 1'b0;
  int idle_cycles = 0;

  // neighbour and destination pools so random words hit known entries
  logic [31:0] pool [12];

  function automatic int find_route(logic [31:0] d);
    for (int i = 0; i < rt_n; i++) if (rt_dest[i] == d) return i;
    return -1;
  endfunction

  function automatic int find_nbr(logic [31:0] d);
    for (int i = 0; i < nb_n; i++) if (nb_addr[i] == d) return i;
    return -1;
  endfunction

  function automatic logic [26:0] cap_cost(logic [27:0] c);
    return (c > {1'b0, INF_COST}) ? INF_COST : c[26:0];
  endfunction

  function automatic bit set_route(int r, logic [31:0] h, logic [26:0] c);
    bit d;
    d = rt_hop[r] != h || rt_cost[r] != c;
    rt_hop[r] = h;
    rt_cost[r] = c;
    return d;
  endfunction

  function automatic dvrt_out_t predict_table(dvrt_in_t w);
    dvrt_out_t o;
    int n, r;
    logic [26:0] c, lk, tot;
    logic [31:0] oth;
    o = '0;
    c = cap_cost({1'b0, w.cost_in});
    case (w.action)
      ACT_ADVERT: begin
        n = find_nbr(w.addr_a);
        if (n < 0) begin
          o.status = ST_INVAL;
        end else begin
          nb_up[n] = 1'b1;
          nb_miss[n] = 2'd0;
          lk = nb_cost[n];
          tot = cap_cost({1'b0, c} + {1'b0, lk});
          if (w.addr_b == my_addr) begin
            r = find_route(w.addr_a);
            if (r >= 0 && rt_cost[r] >= lk) o.changed = set_route(r, w.addr_a, lk);
          end else begin
            r = find_route(w.addr_b);
            if (r < 0) begin
              if (rt_n >= RouteEntries) begin
                o.status = ST_FULL;
              end else begin
                rt_dest[rt_n] = w.addr_b;
                rt_hop[rt_n] = w.addr_a;
                rt_cost[rt_n] = tot;
                rt_n++;
                o.changed = 1'b1;
              end
            end else if (rt_hop[r] == w.addr_a && rt_cost[r] != tot) begin
              rt_cost[r] = tot;
              o.changed = 1'b1;
            end else if (rt_cost[r] > tot) begin
              o.changed = set_route(r, w.addr_a, tot);
            end
          end
        end
      end
      ACT_COST: begin
        if (w.addr_a == my_addr && w.addr_b != my_addr && find_nbr(w.addr_b) >= 0)
          oth = w.addr_b;
        else if (w.addr_b == my_addr && w.addr_a != my_addr && find_nbr(w.addr_a) >= 0)
          oth = w.addr_a;
        else
          o.status = ST_INVAL;
        if (o.status == ST_DONE) begin
          nb_cost[find_nbr(oth)] = c;
          r = find_route(oth);
          if (r >= 0) begin
            if (rt_hop[r] == oth) begin
              o.changed = rt_cost[r] != c;
              rt_cost[r] = c;
            end else if (rt_cost[r] >= c) begin
              o.changed = set_route(r, oth, c);
            end
          end
        end
      end
      ACT_TICK: begin
        for (int i = 0; i < nb_n; i++) if (nb_miss[i] < MISS_MAX) nb_miss[i]++;
        for (int i = 0; i < nb_n; i++) begin
          if (nb_miss[i] >= DownLimit) begin
            nb_up[i] = 1'b0;
            r = find_route(nb_addr[i]);
            if (r >= 0 && rt_hop[r] == nb_addr[i]) begin
              if (rt_cost[r] != INF_COST) o.changed = 1'b1;
              rt_cost[r] = INF_COST;
            end
          end
        end
      end
      ACT_LOOKUP: begin
        if (w.addr_a == my_addr) begin
          o.status = ST_SELF;
        end else begin
          r = find_route(w.addr_a);
          if (r < 0 || rt_cost[r] >= INF_COST) o.status = ST_UNREACH;
          else o.next_hop = rt_hop[r];
        end
      end
      ACT_READ: begin
        if (w.entry_index < rt_n) begin
          o.entry_valid = 1'b1;
          o.entry_dest = rt_dest[w.entry_index];
          o.next_hop = rt_hop[w.entry_index];
          o.entry_cost = rt_cost[w.entry_index];
        end
      end
      ACT_ADD: begin
        if (w.addr_a == my_addr) begin
          o.status = ST_SELF;
        end else begin
          n = find_nbr(w.addr_a);
          r = find_route(w.addr_a);
          if ((n < 0 && nb_n >= NbrEntries) || (r < 0 && rt_n >= RouteEntries)) begin
            o.status = ST_FULL;
          end else begin
            if (r < 0) begin
              rt_dest[rt_n] = w.addr_a;
              rt_hop[rt_n] = w.addr_a;
              rt_cost[rt_n] = c;
              rt_n++;
              o.changed = 1'b1;
            end else if (rt_cost[r] > c) begin
              o.changed = set_route(r, w.addr_a, c);
            end
            if (n < 0) begin
              nb_addr[nb_n] = w.addr_a;
              nb_cost[nb_n] = c;
              nb_up[nb_n] = 1'b1;
              nb_miss[nb_n] = 2'd0;
              nb_n++;
            end
          end
        end
      end
      default: o.status = ST_INVAL;
    endcase
    return o;
  endfunction

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    repeat (g) @(posedge clk);
  endtask

  task automatic send_word(dvrt_in_t w, bit gaps = 1'b1);
    if (gaps) idle_gap();
    while (busy) @(posedge clk);
    start <= 1'b1;
    cmd_word <= w;
    @(posedge clk);
    expected_words = {expected_words, predict_table(w)};
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_own_address(logic [31:0] v);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    my_addr = v;
    @(posedge clk);
  endtask

  function automatic dvrt_in_t make_word(logic [2:0] act, logic [31:0] a,
                                         logic [31:0] b, logic [26:0] c,
                                         logic [3:0] ix);
    dvrt_in_t w;
    w.action = act;
    w.addr_a = a;
    w.addr_b = b;
    w.cost_in = c;
    w.entry_index = ix;
    return w;
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return my_addr;
      1: return $urandom();
      default: return pool[$urandom_range(0, 11)];
    endcase
  endfunction

  function automatic logic [26:0] pick_cost();
    case ($urandom_range(0, 7))
      0: return INF_COST;
      1: return 27'h7ffffff - 27'($urandom_range(0, 3));
      2: return 27'($urandom());
      3: return 27'd0;
      default: return 27'($urandom_range(1, 50));
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    dvrt_out_t e;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, result);
        failed = 1'b1;
      end else begin
        e = expected_words.pop_front();
        if (result.status !== e.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, result.status);
        if (result.changed !== e.changed)
          $display("%0t: changed exp %0d got %0d", $time, e.changed, result.changed);
        if (result.next_hop !== e.next_hop)
          $display("%0t: next_hop exp %h got %h", $time, e.next_hop, result.next_hop);
        if (result.entry_dest !== e.entry_dest)
          $display("%0t: entry_dest exp %h got %h", $time, e.entry_dest, result.entry_dest);
        if (result.entry_cost !== e.entry_cost)
          $display("%0t: entry_cost exp %0d got %0d", $time, e.entry_cost, result.entry_cost);
        if (result.entry_valid !== e.entry_valid)
          $display("%0t: entry_valid exp %0d got %0d", $time, e.entry_valid,
                   result.entry_valid);
        if (result !== e) failed = 1'b1;
      end
    end
  end

  // watchdog on cycles with nothing accepted
  always @(posedge clk) begin
    if (done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    write_own_address(32'hffffffff);
    send_word(make_word(ACT_READ, 0, 0, 0, 4'd0));
    send_word(make_word(ACT_LOOKUP, 32'hffffffff, 0, 0, 0));
    send_word(make_word(ACT_LOOKUP, 32'h0, 0, 0, 0));
    send_word(make_word(ACT_ADD, 32'hffffffff, 0, 5, 0));
    send_word(make_word(ACT_ADVERT, 32'h1, 32'h9, 3, 0));
    send_word(make_word(ACT_ADD, 32'h0, 0, 27'h7ffffff, 0));
    send_word(make_word(ACT_ADD, 32'h0, 0, 4, 0));
    send_word(make_word(ACT_ADD, 32'h0, 0, 9, 0));
    send_word(make_word(ACT_ADVERT, 32'h0, 32'h9, 27'd99999998, 0));
    send_word(make_word(ACT_ADVERT, 32'h0, 32'h9, 2, 0));
    send_word(make_word(ACT_ADVERT, 32'h0, 32'hffffffff, 0, 0));
    send_word(make_word(ACT_COST, 32'hffffffff, 32'h0, 7, 0));
    send_word(make_word(ACT_COST, 32'hffffffff, 32'hffffffff, 7, 0));
    send_word(make_word(ACT_COST, 32'h5, 32'hffffffff, 7, 0));
    send_word(make_word(ACT_LOOKUP, 32'h9, 0, 0, 0));
    repeat (3) send_word(make_word(ACT_TICK, 0, 0, 0, 0));
    send_word(make_word(ACT_LOOKUP, 32'h0, 0, 0, 0));
    send_word(make_word(3'd6, 32'h0, 0, 0, 0));
    send_word(make_word(3'd7, 32'hffffffff, 32'hffffffff, 27'h7ffffff, 4'hf));
    for (int i = 0; i < 3; i++) send_word(make_word(ACT_READ, 0, 0, 0, 4'(i)));
    send_word(make_word(ACT_READ, 0, 0, 0, 4'hf));
  endtask

  // fill both tables to show full handling
  task automatic test_full_tables();
    for (int i = 1; i <= 9; i++)
      send_word(make_word(ACT_ADD, 32'h100 + i, 0, 27'(i), 0));
    for (int i = 0; i < 12; i++)
      send_word(make_word(ACT_ADVERT, 32'h101, 32'h200 + i, 1, 0));
    send_word(make_word(ACT_ADD, 32'h300, 0, 1, 0));
    send_word(make_word(ACT_READ, 0, 0, 0, 4'hf));
  endtask

  task automatic test_random(int count);
    dvrt_in_t w;
    for (int i = 0; i < count; i++) begin
      w.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
      w.addr_a = pick_addr();
      w.addr_b = pick_addr();
      w.cost_in = pick_cost();
      w.entry_index = 4'($urandom());
      if (w.action == ACT_COST && $urandom_range(0, 1)) w.addr_a = my_addr;
      send_word(w, (i % 100) < 70);
      if (i == count / 2) wait_drained();
    end
  endtask

  task automatic reset_pool();
    for (int i = 0; i < 12; i++) pool[i] = $urandom();
    pool[0] = 32'h0;
    pool[1] = 32'hffffffff;
  endtask

  initial begin
    my_addr = '0;
    rt_n = 0;
    nb_n = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_tables();
    wait_drained();
    // the tables stay full, so the random phases mostly exercise lookups and updates
    reset_pool();
    for (int i = 0; i < 12; i++) pool[i] = (i < 9) ? 32'h100 + i : 32'h200 + i;
    write_own_address(32'h0);
    test_random(400);
    reset_pool();
    write_own_address($urandom());
    pool[2] = my_addr;
    test_random(400);
    wait_drained();
    repeat (50) @(posedge clk);
    if (!failed && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* distance_vector_route_table.f */
+incdir+rtl
rtl/dvrt_pkg.sv
rtl/dvrt_ram.sv
rtl/dvrt_ctrl.sv
rtl/dvrt_dp.sv
rtl/distance_vector_route_table.sv
test/testbench.sv
